[sv/utf8d_pkg.sv]
// utf8d_pkg: shared types and constants of the UTF-8 stream decoder.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package utf8d_pkg;

  localparam logic [20:0] REPLACEMENT = 21'h00FFFD;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       stream_end;
  } in_item_t;

  typedef struct packed {
    logic [20:0] code_point;
    logic        is_replacement;
    logic        run_last;
    logic        stream_last;
  } out_item_t;

  // Work for the back end from one input byte: rep_count replacements,
  // then the decoded value if has_cp is set.
  typedef struct packed {
    logic [2:0]  rep_count;
    logic        has_cp;
    logic [20:0] cp;
    logic        stream_end;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

`default_nettype wire

[sv/utf8d_front.sv]
// utf8d_front: accepts bytes, tracks the open sequence and turns each byte
// into a job for the back end. Depends on utf8d_pkg.
`timescale 1ns / 1ps
`default_nettype none

module utf8d_front (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 byte_valid,
  output logic                      byte_ready,
  input  wire utf8d_pkg::in_item_t  byte_item,
  input  wire utf8d_pkg::q_status_t qstat,
  output logic                      push,
  output utf8d_pkg::job_t           job
);

  logic [20:0] partial_value, partial_value_next;
  logic [1:0]  bytes_still_needed, bytes_still_needed_next;
  logic [1:0]  continuations_held, continuations_held_next;
  logic        take;
  logic        lead;
  logic [7:0]  b;

  assign b          = byte_item.data_byte;
  assign byte_ready = !qstat.full;
  assign take       = byte_valid && byte_ready;

  always_comb begin
    partial_value_next      = partial_value;
    bytes_still_needed_next = bytes_still_needed;
    continuations_held_next = continuations_held;
    job.rep_count  = 3'd0;
    job.has_cp     = 1'b0;
    job.cp         = '0;
    job.stream_end = byte_item.stream_end;
    lead           = 1'b1;

    if (bytes_still_needed != 2'd0) begin
      if (b[7:6] == 2'b10) begin
        lead = 1'b0;
        partial_value_next      = {partial_value[14:0], b[5:0]};
        bytes_still_needed_next = bytes_still_needed - 2'd1;
        if (bytes_still_needed == 2'd1) begin
          job.has_cp = 1'b1;
          job.cp     = {partial_value[14:0], b[5:0]};
          partial_value_next      = '0;
          continuations_held_next = 2'd0;
        end else begin
          continuations_held_next = continuations_held + 2'd1;
        end
      end else begin
        // broken sequence: lead byte plus each held continuation
        job.rep_count = 3'd1 + {1'b0, continuations_held};
      end
    end

    if (lead) begin
      partial_value_next      = '0;
      bytes_still_needed_next = 2'd0;
      continuations_held_next = 2'd0;
      if (!b[7]) begin
        job.has_cp = 1'b1;
        job.cp     = {13'd0, b};
      end else if (b[7:5] == 3'b110) begin
        partial_value_next      = {16'd0, b[4:0]};
        bytes_still_needed_next = 2'd1;
      end else if (b[7:4] == 4'b1110) begin
        partial_value_next      = {17'd0, b[3:0]};
        bytes_still_needed_next = 2'd2;
      end else if (b[7:3] == 5'b11110) begin
        partial_value_next      = {18'd0, b[2:0]};
        bytes_still_needed_next = 2'd3;
      end else begin
        job.rep_count = job.rep_count + 3'd1;
      end
    end

    // truncated stream
    if (byte_item.stream_end && bytes_still_needed_next != 2'd0) begin
      job.rep_count = job.rep_count + 3'd1 + {1'b0, continuations_held_next};
      partial_value_next      = '0;
      bytes_still_needed_next = 2'd0;
      continuations_held_next = 2'd0;
    end
  end

  assign push = take && (job.rep_count != 3'd0 || job.has_cp);

  always_ff @(posedge clk) begin
    if (rst) begin
      partial_value      <= '0;
      bytes_still_needed <= 2'd0;
      continuations_held <= 2'd0;
    end else if (take) begin
      partial_value      <= partial_value_next;
      bytes_still_needed <= bytes_still_needed_next;
      continuations_held <= continuations_held_next;
    end
  end

`ifndef ASSERT_OFF
  a_end_idle: assert property (@(posedge clk) disable iff (rst)
    take && byte_item.stream_end |=> bytes_still_needed == 2'd0)
    else $error("sequence left open after end of stream");

  a_end_yields: assert property (@(posedge clk) disable iff (rst)
    take && byte_item.stream_end |-> push)
    else $error("end of stream produced no job");
`endif

endmodule

`default_nettype wire

[sv/utf8d_queue.sv]
// utf8d_queue: short flop-based job queue between front and back end.
// Depends on utf8d_pkg.
`timescale 1ns / 1ps
`default_nettype none

module utf8d_queue #(
  parameter int DEPTH = 4
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 push,
  input  wire utf8d_pkg::job_t      push_job,
  input  wire logic                 pop,
  output utf8d_pkg::job_t           head,
  output utf8d_pkg::q_status_t      qstat
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  utf8d_pkg::job_t entries [DEPTH];
  logic [PTR_W-1:0] wptr, rptr;
  logic [CNT_W-1:0] count;

  assign head        = entries[rptr];
  assign qstat.full  = (count == CNT_W'(DEPTH));
  assign qstat.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == PTR_W'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == PTR_W'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && qstat.full))
    else $error("transfer into a full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !(pop && qstat.empty))
    else $error("pop from an empty queue");
`endif

endmodule

`default_nettype wire

[sv/utf8d_back.sv]
// utf8d_back: expands jobs into result items, one per cycle while cp_ready
// allows, behind an output register. Depends on utf8d_pkg.
`timescale 1ns / 1ps
`default_nettype none

module utf8d_back (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire utf8d_pkg::q_status_t qstat,
  input  wire utf8d_pkg::job_t      head,
  output logic                      pop,
  output logic                      cp_valid,
  input  wire logic                 cp_ready,
  output utf8d_pkg::out_item_t      cp_item
);

  utf8d_pkg::job_t      cur;
  logic                 cur_valid;
  utf8d_pkg::out_item_t item;
  logic                 last;
  logic                 adv;

  always_comb begin
    if (cur.rep_count != 3'd0) begin
      last                = (cur.rep_count == 3'd1) && !cur.has_cp;
      item.code_point     = utf8d_pkg::REPLACEMENT;
      item.is_replacement = 1'b1;
    end else begin
      last                = 1'b1;
      item.code_point     = cur.cp;
      item.is_replacement = 1'b0;
    end
    item.run_last    = last;
    item.stream_last = last && cur.stream_end;
  end

  assign adv = cur_valid && (!cp_valid || cp_ready);
  assign pop = !qstat.empty && (!cur_valid || (adv && last));

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      cp_valid  <= 1'b0;
    end else begin
      if (pop) begin
        cur_valid <= 1'b1;
      end else if (adv && last) begin
        cur_valid <= 1'b0;
      end
      if (adv) begin
        cp_valid <= 1'b1;
      end else if (cp_ready) begin
        cp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head;
    end else if (adv && cur.rep_count != 3'd0) begin
      cur.rep_count <= cur.rep_count - 3'd1;
    end
    if (adv) begin
      cp_item <= item;
    end
  end

`ifndef ASSERT_OFF
  a_rep_value: assert property (@(posedge clk) disable iff (rst)
    cp_valid && cp_item.is_replacement |-> cp_item.code_point == utf8d_pkg::REPLACEMENT)
    else $error("replacement flag on a non-replacement value");

  a_stream_run: assert property (@(posedge clk) disable iff (rst)
    cp_valid && cp_item.stream_last |-> cp_item.run_last)
    else $error("stream end not on last result of its byte");
`endif

endmodule

`default_nettype wire

[sv/utf8_stream_decoder_top.sv]
// utf8_stream_decoder_top: top level of the UTF-8 stream decoder.
// Instantiates utf8d_front, utf8d_queue and utf8d_back; uses utf8d_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Streaming UTF-8 decoder. One byte is taken per cycle while byte_ready is
// high; each byte yields zero to four result items, and the result port
// delivers at most one item per cycle from its output register. A byte that
// only opens or extends a sequence yields nothing; a well-formed stream
// therefore runs at one byte per cycle while cp_ready stays high. An error
// burst of k replacements holds the result side for k items, absorbed by a
// job queue of QUEUE_DEPTH entries between the byte classifier and the result
// expander; byte_ready drops only while that queue is full. Overlong forms
// and surrogates pass through as decoded values.
module utf8_stream_decoder_top #(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 byte_valid,
  output logic                      byte_ready,
  input  wire utf8d_pkg::in_item_t  byte_item,
  output logic                      cp_valid,
  input  wire logic                 cp_ready,
  output utf8d_pkg::out_item_t      cp_item
);

  utf8d_pkg::q_status_t qstat;
  utf8d_pkg::job_t      push_job;
  utf8d_pkg::job_t      head;
  logic                 push;
  logic                 pop;

  utf8d_front u_front (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_ready (byte_ready),
    .byte_item  (byte_item),
    .qstat      (qstat),
    .push       (push),
    .job        (push_job)
  );

  utf8d_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .qstat    (qstat)
  );

  utf8d_back u_back (
    .clk      (clk),
    .rst      (rst),
    .qstat    (qstat),
    .head     (head),
    .pop      (pop),
    .cp_valid (cp_valid),
    .cp_ready (cp_ready),
    .cp_item  (cp_item)
  );

endmodule

`default_nettype wire
